FILE: design/pad_pkg.sv
// Shared types and constants for the phase-angle dimmer control block.
// Used by pad_delay_calc and phase_angle_dimmer_control; no dependencies.
package pad_pkg;

    // Command codes carried on s_tuser
    typedef logic [2:0] cmd_t;
    localparam cmd_t CMD_TICK = 3'd0;
    localparam cmd_t CMD_EDGE = 3'd1;
    localparam cmd_t CMD_UP   = 3'd2;
    localparam cmd_t CMD_DOWN = 3'd3;
    localparam cmd_t CMD_OFF  = 3'd4;
    localparam cmd_t CMD_SET  = 3'd5;

    // Configuration register indexes
    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_HALF_PERIOD  = 2'd0;
    localparam cfg_idx_t CFG_STEP_SIZE    = 2'd1;
    localparam cfg_idx_t CFG_REPORT_DELAY = 2'd2;

    // Field widths
    localparam int TICK_W   = 14;
    localparam int LEVEL_W  = 7;
    localparam int REQ_W    = 10;
    localparam int REPORT_W = 24;

    typedef logic [TICK_W-1:0]   tick_t;
    typedef logic [LEVEL_W-1:0]  level_t;
    typedef logic [REPORT_W-1:0] rpt_t;

    localparam level_t FULL_LEVEL = 7'd100;

    // Reset values of the configuration registers
    localparam tick_t  HALF_PERIOD_RST  = 14'd8333;
    localparam level_t STEP_SIZE_RST    = 7'd10;
    localparam rpt_t   REPORT_DELAY_RST = 24'd5000000;

    // Division by 100 through a reciprocal: q = (p * RECIP_100) >> RECIP_SHIFT,
    // exact for every product p below 2^PROD_W.
    localparam int PROD_W      = TICK_W + LEVEL_W;
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_W     = 22;
    localparam logic [RECIP_W-1:0] RECIP_100 = 22'd2684355;

    // Cycles from a level or half period change until off_delay is valid
    localparam int DELAY_LATENCY = 3;
    typedef logic [1:0] busy_t;

endpackage

FILE: design/pad_delay_calc.sv
// Off-delay pipeline: half_period - floor(half_period * level / 100).
// Three register stages; depends on pad_pkg.
module pad_delay_calc
    import pad_pkg::*;
(
    input  logic   aclk,
    input  tick_t  half_period,
    input  level_t brightness,
    output tick_t  off_delay
);

    logic [PROD_W-1:0]         prod_reg;
    tick_t                     hp_d1_reg;
    tick_t                     hp_d2_reg;
    tick_t                     on_time_reg;
    tick_t                     off_delay_reg;
    logic [PROD_W+RECIP_W-1:0] scaled;

    // Reciprocal multiply, the quotient sits above the shift point
    assign scaled = {{RECIP_W{1'b0}}, prod_reg} * {{PROD_W{1'b0}}, RECIP_100};

    // Stage 1: on-time product; stage 2: divide by 100; stage 3: subtract
    always_ff @(posedge aclk) begin
        prod_reg      <= {{LEVEL_W{1'b0}}, half_period} * {{TICK_W{1'b0}}, brightness};
        hp_d1_reg     <= half_period;
        on_time_reg   <= scaled[RECIP_SHIFT+TICK_W-1:RECIP_SHIFT];
        hp_d2_reg     <= hp_d1_reg;
        off_delay_reg <= hp_d2_reg - on_time_reg;
    end

    assign off_delay = off_delay_reg;

endmodule

FILE: design/phase_angle_dimmer_control.sv
// Phase-angle dimmer control: one event in, one status item out per event.
// Top level; depends on pad_pkg and pad_delay_calc.
//
// Each accepted event (tick, zero-crossing edge, step up/down, off, set level)
// yields one result item with gate, level and report. Events pass through an
// input register and one compute stage into an output register, so one event
// per cycle is accepted while the output is not stalled by m_tready. The
// exception: the off-delay is produced by a three-stage multiply and
// reciprocal-divide pipeline, so a zero-crossing edge that follows a level
// change or a half-period write waits in the input register until that
// pipeline has settled. Configuration writes are always accepted and take
// effect at once; write only while idle.
module phase_angle_dimmer_control
    import pad_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Event input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [9:0] new_level, rest zero
    input  logic [2:0]  s_tuser,    // [2:0] command
    // Result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [0] gate, [7:1] level, [8] report, rest zero
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_idx_t    cfg_index,
    input  logic [23:0] cfg_data
);

    // Configuration registers
    tick_t  half_period_reg;
    level_t step_size_reg;
    rpt_t   report_delay_reg;

    // Input register
    logic       in_valid_reg;
    cmd_t       in_cmd_reg;
    logic [REQ_W-1:0] in_req_reg;

    // Dimmer state
    level_t brightness_reg, brightness_next;
    tick_t  fire_cnt_reg, fire_cnt_next;
    logic   fire_armed_reg, fire_armed_next;
    logic   gate_reg, gate_next;
    rpt_t   report_cnt_reg, report_cnt_next;
    logic   report_armed_reg, report_armed_next;
    logic   report_next;
    busy_t  busy_reg, busy_next;

    // Output register
    logic   out_valid_reg;
    logic   out_gate_reg;
    level_t out_level_reg;
    logic   out_report_reg;

    tick_t  off_delay;
    logic   advance;
    logic   edge_blocked;
    logic   hp_write;
    logic [LEVEL_W:0] level_up;

    assign cfg_ready = 1'b1;
    assign hp_write  = cfg_valid && (cfg_index == CFG_HALF_PERIOD);

    pad_delay_calc u_delay_calc (
        .aclk        (aclk),
        .half_period (half_period_reg),
        .brightness  (brightness_reg),
        .off_delay   (off_delay)
    );

    // Handshake: an edge waits while off_delay is still settling
    assign edge_blocked = (in_cmd_reg == CMD_EDGE) && (busy_reg != '0);
    assign advance  = in_valid_reg && !edge_blocked && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign level_up = {1'b0, brightness_reg} + {1'b0, step_size_reg};

    // Event processing
    always_comb begin
        brightness_next   = brightness_reg;
        fire_cnt_next     = fire_cnt_reg;
        fire_armed_next   = fire_armed_reg;
        gate_next         = gate_reg;
        report_cnt_next   = report_cnt_reg;
        report_armed_next = report_armed_reg;
        report_next       = 1'b0;
        busy_next         = (busy_reg != '0) ? busy_reg - busy_t'(1) : busy_reg;
        if (hp_write) begin
            busy_next = busy_t'(DELAY_LATENCY);
        end
        if (advance) begin
            case (in_cmd_reg)
                CMD_TICK: begin
                    if (fire_armed_reg) begin
                        if (fire_cnt_reg <= tick_t'(1)) begin
                            fire_cnt_next   = '0;
                            fire_armed_next = 1'b0;
                            gate_next       = 1'b1;
                        end else begin
                            fire_cnt_next = fire_cnt_reg - tick_t'(1);
                        end
                    end
                    if (report_armed_reg) begin
                        if (report_cnt_reg <= rpt_t'(1)) begin
                            report_cnt_next   = '0;
                            report_armed_next = 1'b0;
                            report_next       = 1'b1;
                        end else begin
                            report_cnt_next = report_cnt_reg - rpt_t'(1);
                        end
                    end
                end
                CMD_EDGE: begin
                    if (brightness_reg == '0) begin
                        gate_next       = 1'b0;
                        fire_armed_next = 1'b0;
                    end else if (brightness_reg >= FULL_LEVEL || off_delay == '0) begin
                        gate_next       = 1'b1;
                        fire_armed_next = 1'b0;
                    end else begin
                        gate_next       = 1'b0;
                        fire_cnt_next   = off_delay;
                        fire_armed_next = 1'b1;
                    end
                end
                CMD_UP: begin
                    brightness_next   = (level_up > {1'b0, FULL_LEVEL}) ?
                                        FULL_LEVEL : level_up[LEVEL_W-1:0];
                    report_cnt_next   = report_delay_reg;
                    report_armed_next = 1'b1;
                    busy_next         = busy_t'(DELAY_LATENCY);
                end
                CMD_DOWN: begin
                    brightness_next   = (brightness_reg > step_size_reg) ?
                                        brightness_reg - step_size_reg : '0;
                    report_cnt_next   = report_delay_reg;
                    report_armed_next = 1'b1;
                    busy_next         = busy_t'(DELAY_LATENCY);
                end
                CMD_OFF: begin
                    if (brightness_reg != '0) begin
                        brightness_next   = '0;
                        report_cnt_next   = report_delay_reg;
                        report_armed_next = 1'b1;
                        busy_next         = busy_t'(DELAY_LATENCY);
                    end
                end
                CMD_SET: begin
                    if (in_req_reg <= REQ_W'(FULL_LEVEL)) begin
                        brightness_next = in_req_reg[LEVEL_W-1:0];
                        busy_next       = busy_t'(DELAY_LATENCY);
                    end
                end
                default: begin
                    // unused codes change nothing
                end
            endcase
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg  <= HALF_PERIOD_RST;
            step_size_reg    <= STEP_SIZE_RST;
            report_delay_reg <= REPORT_DELAY_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_HALF_PERIOD:  half_period_reg  <= cfg_data[TICK_W-1:0];
                CFG_STEP_SIZE:    step_size_reg    <= cfg_data[LEVEL_W-1:0];
                CFG_REPORT_DELAY: report_delay_reg <= cfg_data[REPORT_W-1:0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg <= s_tuser;
            in_req_reg <= s_tdata[REQ_W-1:0];
        end
    end

    // Dimmer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg   <= '0;
            fire_cnt_reg     <= '0;
            fire_armed_reg   <= 1'b0;
            gate_reg         <= 1'b0;
            report_cnt_reg   <= '0;
            report_armed_reg <= 1'b0;
            busy_reg         <= '0;
        end else begin
            brightness_reg   <= brightness_next;
            fire_cnt_reg     <= fire_cnt_next;
            fire_armed_reg   <= fire_armed_next;
            gate_reg         <= gate_next;
            report_cnt_reg   <= report_cnt_next;
            report_armed_reg <= report_armed_next;
            busy_reg         <= busy_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_gate_reg   <= gate_next;
            out_level_reg  <= brightness_next;
            out_report_reg <= report_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_report_reg, out_level_reg, out_gate_reg};

`ifndef SYNTH
    // An edge never reads off_delay before the pipeline has settled
    a_edge_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_cmd_reg == CMD_EDGE) |-> (busy_reg == '0))
        else $error("edge processed while off_delay was settling");

    // Full brightness turns the gate on at the edge itself
    a_full_on: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_cmd_reg == CMD_EDGE && brightness_reg == FULL_LEVEL)
        |=> (out_gate_reg && gate_reg))
        else $error("gate not on after edge at full brightness");

    // The report pulse only comes with a tick
    a_report_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_cmd_reg != CMD_TICK) |=> !out_report_reg)
        else $error("report raised on a non-tick event");

    // Brightness stays within 0..100
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (brightness_reg <= FULL_LEVEL))
        else $error("brightness above full level");
`endif

endmodule
